// ===== sv/pse_pkg.sv =====
// Shared types, codes and constants for the postfix stack evaluator.
// Used by pse_stack, pse_alu and postfix_stack_evaluator_top; depends on nothing.
`default_nettype none

package pse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int WORD_W          = 48;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [2:0] MODE_PUSH = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam word_t FX_MAX = 48'h7FFF_FFFF_FFFF;
  localparam word_t FX_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic push;
    logic replace;
    logic clear;
    logic rd;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic two;
  } stk_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPERAND,
    S_WAIT,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_PREP,
    A_RUN,
    A_FIN
  } alu_state_t;

endpackage

`default_nettype wire

// ===== sv/postfix_stack_evaluator_top.sv =====
// Top level of the postfix stack evaluator: token sequencer, push conversion and
// result register. Depends on pse_pkg, pse_stack and pse_alu.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    mode, number, last_token
//   out      output     out_valid/out_ready  value, status
//
// A new token is accepted only once the previous token has finished. Multiply and
// divide run the one-bit-per-cycle loop of the shared adder in the arithmetic unit;
// add and subtract take a single step.
// Reset clears the entry count, the error code and the output valid.
// A result waiting for out_ready holds only the last token of the next expression.
`default_nettype none

module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] number,
  input  logic               last_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] value,
  output logic [2:0]         status
);

  localparam int W     = pse_pkg::WORD_W;
  localparam int EXT_W = W + 32;

  pse_pkg::ctl_state_t state, state_next;

  logic [2:0]         tok_mode;
  logic [31:0]        tok_number;
  logic               tok_last;
  logic [2:0]         err, err_next;
  logic               load_out;
  pse_pkg::word_t     out_value;
  logic [2:0]         out_status;

  pse_pkg::stk_cmd_t  cmd;
  pse_pkg::stk_stat_t stat;
  pse_pkg::word_t     wdata, top, rdata;
  pse_pkg::alu_req_t  req;
  pse_pkg::alu_op_t   op_sel;
  logic               alu_done;
  pse_pkg::word_t     alu_result;

  logic [EXT_W-1:0]   ext_sh;
  logic               fits;
  pse_pkg::word_t     push_word;

  pse_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .wdata(wdata),
    .top  (top),
    .rdata(rdata),
    .stat (stat)
  );

  pse_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .a     (rdata),
    .b     (top),
    .done  (alu_done),
    .result(alu_result)
  );

  assign ext_sh    = {{(EXT_W-32){tok_number[31]}}, tok_number} << FRAC_BITS;
  assign fits      = (ext_sh[EXT_W-1:W-1] == '0) || (ext_sh[EXT_W-1:W-1] == '1);
  assign push_word = fits ? ext_sh[W-1:0]
                          : (tok_number[31] ? pse_pkg::FX_MIN : pse_pkg::FX_MAX);

  always_comb begin
    case (tok_mode)
      pse_pkg::MODE_SUB: op_sel = pse_pkg::OP_SUB;
      pse_pkg::MODE_MUL: op_sel = pse_pkg::OP_MUL;
      pse_pkg::MODE_DIV: op_sel = pse_pkg::OP_DIV;
      default:           op_sel = pse_pkg::OP_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::S_IDLE;
      err   <= pse_pkg::ST_OK;
    end else begin
      state <= state_next;
      err   <= err_next;
    end
  end

  always_comb begin
    state_next = state;
    err_next   = err;
    in_ready   = 1'b0;
    cmd        = '0;
    req.start  = 1'b0;
    req.op     = op_sel;
    wdata      = push_word;
    load_out   = 1'b0;
    unique case (state)
      pse_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = pse_pkg::S_DECODE;
        end
      end
      pse_pkg::S_DECODE: begin
        state_next = pse_pkg::S_FINISH;
        if (err == pse_pkg::ST_OK) begin
          unique case (tok_mode) inside
            pse_pkg::MODE_PUSH: begin
              if (stat.full) begin
                err_next = pse_pkg::ST_OVER;
              end else begin
                cmd.push = 1'b1;
              end
            end
            pse_pkg::MODE_ADD, pse_pkg::MODE_SUB, pse_pkg::MODE_MUL,
            pse_pkg::MODE_DIV: begin
              if (!stat.two) begin
                err_next = pse_pkg::ST_UNDER;
              end else if ((tok_mode == pse_pkg::MODE_DIV) && (top == '0)) begin
                err_next = pse_pkg::ST_DIVZ;
              end else begin
                cmd.rd     = 1'b1;
                state_next = pse_pkg::S_OPERAND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      pse_pkg::S_OPERAND: begin
        req.start  = 1'b1;
        state_next = pse_pkg::S_WAIT;
      end
      pse_pkg::S_WAIT: begin
        wdata = alu_result;
        if (alu_done) begin
          cmd.replace = 1'b1;
          state_next  = pse_pkg::S_FINISH;
        end
      end
      pse_pkg::S_FINISH: begin
        if (!tok_last) begin
          state_next = pse_pkg::S_IDLE;
        end else if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          cmd.clear  = 1'b1;
          err_next   = pse_pkg::ST_OK;
          state_next = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pse_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_mode   <= mode;
      tok_number <= number;
      tok_last   <= last_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (err != pse_pkg::ST_OK) begin
        out_value  <= '0;
        out_status <= err;
      end else if (stat.empty) begin
        out_value  <= '0;
        out_status <= pse_pkg::ST_EMPTY;
      end else begin
        out_value  <= top;
        out_status <= pse_pkg::ST_OK;
      end
    end
  end

  assign value  = $signed(out_value);
  assign status = out_status;

endmodule

`default_nettype wire

// ===== sv/pse_stack.sv =====
// Operand stack: a single-port-write, registered-read memory with an entry count
// and a copy of the top entry. Depends on pse_pkg.
`default_nettype none

module pse_stack #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pse_pkg::stk_cmd_t   cmd,
  input  pse_pkg::word_t      wdata,
  output pse_pkg::word_t      top,
  output pse_pkg::word_t      rdata,
  output pse_pkg::stk_stat_t  stat
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  pse_pkg::word_t mem [STACK_DEPTH];
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_m2;
  logic [AW-1:0]  waddr;
  logic           we;

  assign count_m2 = count - CW'(2);
  assign we       = cmd.push || cmd.replace;
  assign waddr    = cmd.push ? count[AW-1:0] : count_m2[AW-1:0];

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(STACK_DEPTH));
  assign stat.two   = (count >= CW'(2));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[count_m2[AW-1:0]];
    end
    if (we) begin
      top <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.replace) begin
      count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/pse_alu.sv =====
// Shared iterative arithmetic unit: add and subtract in one step, shift-add
// multiply and restoring divide one bit per cycle on one adder. Depends on pse_pkg.
`default_nettype none

module pse_alu #(
  parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  input  pse_pkg::word_t    a,
  input  pse_pkg::word_t    b,
  output logic              done,
  output pse_pkg::word_t    result
);

  localparam int W     = pse_pkg::WORD_W;
  localparam int DW    = W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW);
  localparam logic [CNT_W-1:0] LAST_MUL = CNT_W'(W - 1);
  localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(DW - 1);

  pse_pkg::alu_state_t state, state_next;

  pse_pkg::alu_op_t op;
  pse_pkg::word_t   opa, opb;
  pse_pkg::word_t   mcand, hi, lo;
  logic [DW-1:0]    dvd;
  logic             neg, big;
  logic [CNT_W-1:0] cnt;

  pse_pkg::word_t   mag_a, mag_b;
  logic [W:0]       add_x, add_y, sum;
  logic             add_cin;
  logic [W:0]       rem_sh;
  logic             is_div, last_iter;
  logic [2*W-1:0]   prod_sh;
  pse_pkg::word_t   fin_mag;
  logic             fin_big;
  pse_pkg::word_t   sat_val;

  assign mag_a  = opa[W-1] ? (~opa + W'(1)) : opa;
  assign mag_b  = opb[W-1] ? (~opb + W'(1)) : opb;
  assign is_div = (op == pse_pkg::OP_DIV);
  assign rem_sh = {hi, dvd[DW-1]};

  always_comb begin
    if (state == pse_pkg::A_PREP) begin
      add_x   = {1'b0, opa};
      add_y   = (op == pse_pkg::OP_SUB) ? ~{1'b0, opb} : {1'b0, opb};
      add_cin = (op == pse_pkg::OP_SUB);
    end else if (is_div) begin
      add_x   = rem_sh;
      add_y   = ~{1'b0, mcand};
      add_cin = 1'b1;
    end else begin
      add_x   = {1'b0, hi};
      add_y   = lo[0] ? {1'b0, mcand} : '0;
      add_cin = 1'b0;
    end
    sum = add_x + add_y + {{W{1'b0}}, add_cin};
  end

  assign last_iter = (cnt == (is_div ? LAST_DIV : LAST_MUL));

  assign prod_sh = {hi, lo} >> FRAC_BITS;

  always_comb begin
    if (is_div) begin
      fin_mag = lo;
      fin_big = big;
    end else begin
      fin_mag = prod_sh[W-1:0];
      fin_big = |prod_sh[2*W-1:W];
    end
    if (neg) begin
      sat_val = (fin_big || (fin_mag > pse_pkg::FX_MIN)) ? pse_pkg::FX_MIN
                                                        : (~fin_mag + W'(1));
    end else begin
      sat_val = (fin_big || (fin_mag > pse_pkg::FX_MAX)) ? pse_pkg::FX_MAX : fin_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pse_pkg::A_IDLE: begin
        if (req.start) begin
          state_next = pse_pkg::A_PREP;
        end
      end
      pse_pkg::A_PREP: begin
        if (op == pse_pkg::OP_ADD || op == pse_pkg::OP_SUB) begin
          state_next = pse_pkg::A_IDLE;
        end else begin
          state_next = pse_pkg::A_RUN;
        end
      end
      pse_pkg::A_RUN: begin
        if (last_iter) begin
          state_next = pse_pkg::A_FIN;
        end
      end
      pse_pkg::A_FIN: begin
        state_next = pse_pkg::A_IDLE;
      end
      default: begin
        state_next = pse_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == pse_pkg::A_PREP) &&
               (op == pse_pkg::OP_ADD || op == pse_pkg::OP_SUB)) ||
              (state == pse_pkg::A_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pse_pkg::A_IDLE: begin
        if (req.start) begin
          op  <= req.op;
          opa <= a;
          opb <= b;
        end
      end
      pse_pkg::A_PREP: begin
        result <= sum[W-1:0];
        neg    <= opa[W-1] ^ opb[W-1];
        big    <= 1'b0;
        cnt    <= '0;
        hi     <= '0;
        dvd    <= DW'(mag_a) << FRAC_BITS;
        if (is_div) begin
          mcand <= mag_b;
          lo    <= '0;
        end else begin
          mcand <= mag_a;
          lo    <= mag_b;
        end
      end
      pse_pkg::A_RUN: begin
        cnt <= cnt + CNT_W'(1);
        if (is_div) begin
          hi  <= sum[W] ? rem_sh[W-1:0] : sum[W-1:0];
          lo  <= {lo[W-2:0], ~sum[W]};
          big <= big | lo[W-1];
          dvd <= dvd << 1;
        end else begin
          hi <= sum[W:1];
          lo <= {sum[0], lo[W-1:1]};
        end
      end
      pse_pkg::A_FIN: begin
        result <= sat_val;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/rpn_result_checker.sv =====
// Checker for the postfix stack evaluator: watches both channels, predicts each result
// on its own operand stack and compares value and status. Depends on pse_pkg.
`timescale 1ns / 100ps

module rpn_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] number,
  input  logic               last_token,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [47:0] value,
  input  logic [2:0]         status,
  output int                 fail_count,
  output int                 waiting,
  output int                 result_count,
  output int                 error_results
);

  localparam int FRAC = pse_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    pse_pkg::word_t value;
    logic [2:0]     status;
  } outcome_t;

  pse_pkg::word_t operand_stack [pse_pkg::STACK_DEPTH_DEF];
  int             depth;
  logic [2:0]     err_code;
  outcome_t       expected_results [$];
  outcome_t       oldest;
  outcome_t       predicted;

  initial begin
    fail_count    = 0;
    waiting       = 0;
    result_count  = 0;
    error_results = 0;
    depth         = 0;
    err_code      = pse_pkg::ST_OK;
  end

  function automatic logic [47:0] magnitude(pse_pkg::word_t x);
    logic [47:0] r;
    r = x[47] ? -x : x;
    return r;
  endfunction

  function automatic pse_pkg::word_t saturate(logic neg, logic [127:0] mag);
    logic [47:0] r;
    if (neg) begin
      if (mag > {80'b0, pse_pkg::FX_MIN}) return pse_pkg::FX_MIN;
      r = mag[47:0];
      return -r;
    end
    if (mag > {80'b0, pse_pkg::FX_MAX}) return pse_pkg::FX_MAX;
    return mag[47:0];
  endfunction

  function automatic pse_pkg::word_t int_to_fixed(logic [31:0] n);
    logic [31:0]  m32;
    logic [127:0] mag;
    m32 = n[31] ? ~n + 32'd1 : n;
    mag = {96'b0, m32} << FRAC;
    return saturate(n[31], mag);
  endfunction

  function automatic pse_pkg::word_t fixed_mul(pse_pkg::word_t a, pse_pkg::word_t b);
    logic [127:0] prod;
    prod = ({80'b0, magnitude(a)} * {80'b0, magnitude(b)}) >> FRAC;
    return saturate(a[47] ^ b[47], prod);
  endfunction

  function automatic pse_pkg::word_t fixed_div(pse_pkg::word_t a, pse_pkg::word_t b);
    logic [127:0] num;
    logic [127:0] quo;
    num = {80'b0, magnitude(a)} << FRAC;
    quo = num / {80'b0, magnitude(b)};
    return saturate(a[47] ^ b[47], quo);
  endfunction

  function automatic void evaluate_token(logic [2:0] m, logic [31:0] n);
    pse_pkg::word_t lhs;
    pse_pkg::word_t rhs;
    pse_pkg::word_t res;
    if (err_code != pse_pkg::ST_OK) return;
    if (m == pse_pkg::MODE_PUSH) begin
      if (depth >= pse_pkg::STACK_DEPTH_DEF) begin
        err_code = pse_pkg::ST_OVER;
        return;
      end
      operand_stack[depth] = int_to_fixed(n);
      depth++;
      return;
    end
    if (m > pse_pkg::MODE_DIV) return;
    if (depth < 2) begin
      err_code = pse_pkg::ST_UNDER;
      return;
    end
    rhs = operand_stack[depth-1];
    lhs = operand_stack[depth-2];
    case (m)
      pse_pkg::MODE_ADD: res = lhs + rhs;
      pse_pkg::MODE_SUB: res = lhs - rhs;
      pse_pkg::MODE_MUL: res = fixed_mul(lhs, rhs);
      default: begin
        if (rhs == '0) begin
          err_code = pse_pkg::ST_DIVZ;
          return;
        end
        res = fixed_div(lhs, rhs);
      end
    endcase
    depth--;
    operand_stack[depth-1] = res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      depth    = 0;
      err_code = pse_pkg::ST_OK;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d status %0d",
                   $time, value, status);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (oldest.status != pse_pkg::ST_OK) error_results++;
          if (value !== oldest.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, $signed(oldest.value), value);
            fail_count++;
          end
          if (status !== oldest.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, oldest.status, status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        evaluate_token(mode, number);
        if (last_token) begin
          if (err_code != pse_pkg::ST_OK) begin
            predicted.value  = '0;
            predicted.status = err_code;
          end else if (depth == 0) begin
            predicted.value  = '0;
            predicted.status = pse_pkg::ST_EMPTY;
          end else begin
            predicted.value  = operand_stack[depth-1];
            predicted.status = pse_pkg::ST_OK;
          end
          expected_results = {expected_results, predicted};
          depth    = 0;
          err_code = pse_pkg::ST_OK;
        end
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the postfix stack evaluator bench: clock, reset, token stimulus and the verdict.
// Depends on pse_pkg, postfix_stack_evaluator_top and rpn_result_checker.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int RANDOM_TOKENS = 900;
  localparam int HOLD_START    = 3000;
  localparam int HOLD_CYCLES   = 2500;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [2:0]         mode       = pse_pkg::MODE_PUSH;
  logic signed [31:0] number     = '0;
  logic               last_token = 1'b0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic signed [47:0] value;
  logic [2:0]         status;
  logic               calm       = 1'b0;

  int fail_count;
  int waiting;
  int result_count;
  int error_results;
  int tokens_sent   = 0;
  int counted       = 0;
  int expressions   = 0;

  always #5 clk = ~clk;

  postfix_stack_evaluator_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .number     (number),
    .last_token (last_token),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status)
  );

  rpn_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .number        (number),
    .last_token    (last_token),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value         (value),
    .status        (status),
    .fail_count    (fail_count),
    .waiting       (waiting),
    .result_count  (result_count),
    .error_results (error_results)
  );

  task automatic send_token(logic [2:0] m, logic [31:0] n, logic l);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    mode       <= m;
    number     <= n;
    last_token <= l;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tokens_sent++;
    if (m <= pse_pkg::MODE_DIV) counted++;
    if (l) expressions++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4, 5: return 32'($urandom_range(32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_expression();
    logic [2:0]  modes [$];
    logic [31:0] nums [$];
    int kind;
    int pushes_left;
    int depth;
    int final_depth;
    kind = $urandom_range(99);
    if (kind < 78) begin
      pushes_left = $urandom_range(1, ($urandom_range(9) == 0) ? 16 : 6);
      final_depth = ($urandom_range(9) == 0) ? 2 : 1;
      depth = 0;
      while (pushes_left > 0 || depth > final_depth) begin
        if ($urandom_range(19) == 0) begin
          modes = {modes, 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO))};
          nums  = {nums, 32'($urandom)};
        end
        if (pushes_left > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
          modes = {modes, pse_pkg::MODE_PUSH};
          nums  = {nums, pick_operand()};
          pushes_left--;
          depth++;
        end else begin
          modes = {modes, 3'($urandom_range(pse_pkg::MODE_DIV, pse_pkg::MODE_ADD))};
          nums  = {nums, 32'($urandom)};
          depth--;
        end
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(20, 17)) begin
        modes = {modes, pse_pkg::MODE_PUSH};
        nums  = {nums, pick_operand()};
      end
      repeat ($urandom_range(3)) begin
        modes = {modes, 3'($urandom_range(pse_pkg::MODE_DIV, pse_pkg::MODE_ADD))};
        nums  = {nums, 32'($urandom)};
      end
    end else begin
      repeat ($urandom_range(12, 1)) begin
        modes = {modes, 3'($urandom_range(7))};
        nums  = {nums, (($urandom_range(1) == 1) ? pick_operand() : 32'($urandom))};
      end
    end
    foreach (modes[i]) send_token(modes[i], nums[i], i == modes.size() - 1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_token(MODE_UNUSED_HI, 32'd0, 1'b1);

    send_token(pse_pkg::MODE_PUSH, 32'd7, 1'b0);
    send_token(pse_pkg::MODE_ADD, 32'd0, 1'b1);

    send_token(pse_pkg::MODE_PUSH, 32'd5, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'd0, 1'b0);
    send_token(pse_pkg::MODE_DIV, 32'd0, 1'b1);

    send_token(pse_pkg::MODE_PUSH, 32'd1, 1'b0);
    send_token(pse_pkg::MODE_ADD, 32'd0, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'd3, 1'b0);
    send_token(pse_pkg::MODE_SUB, 32'd0, 1'b1);

    send_token(pse_pkg::MODE_PUSH, 32'h8000_0000, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'h8000_0000, 1'b0);
    send_token(pse_pkg::MODE_ADD, 32'd0, 1'b1);

    send_token(pse_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b0);
    send_token(pse_pkg::MODE_MUL, 32'd0, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'h8000_0000, 1'b0);
    send_token(pse_pkg::MODE_MUL, 32'd0, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b0);
    send_token(pse_pkg::MODE_SUB, 32'd0, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'd3, 1'b0);
    send_token(pse_pkg::MODE_DIV, 32'd0, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'd1, 1'b0);
    send_token(MODE_UNUSED_LO, 32'hFFFF_FFFF, 1'b0);
    send_token(pse_pkg::MODE_PUSH, 32'hFFFF_FFFE, 1'b1);

    counted = 0;
    while (counted < RANDOM_TOKENS) begin
      calm = (counted >= 300 && counted < 450);
      run_expression();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d tokens in %0d expressions;", tokens_sent, expressions);
    $display("%0d results checked, %0d with error status.", result_count, error_results);
    if (waiting != 0) $display("%0d expected results never arrived", waiting);
    if (fail_count == 0 && waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    int cycle;
    cycle = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == HOLD_START) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || $urandom_range(99) >= 17;
    end
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
